/* sv/salts_pkg.sv */
`timescale 1ns / 1ps

package salts_pkg;

    // Default geometry of the tag store.
    localparam int SETS_DEF     = 256;
    localparam int WAYS_DEF     = 4;
    localparam int TAG_BITS_DEF = 32;

    // Field widths fixed by the request and result words.
    localparam int SET_IDX_W = 8;
    localparam int TAG_IN_W  = 32;
    localparam int STATE_W   = 3;

    // Request operations.
    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_CHANGE = 2'd1,
        REQ_TOUCH  = 2'd2,
        REQ_INSERT = 2'd3
    } t_req_op;

    // Coherence states: owned and modified count as dirty for the victim report.
    localparam logic [STATE_W-1:0] ST_OWNED    = 3'd3;
    localparam logic [STATE_W-1:0] ST_MODIFIED = 3'd4;
    localparam logic [STATE_W-1:0] ST_INVALID  = 3'd0;

    // Result word handed from the update logic to the output register.
    typedef struct packed {
        logic [STATE_W-1:0] line_state;
        logic               victim_dirty;
    } t_result;

endpackage

/* sv/salts_mem.sv */
`timescale 1ns / 1ps

module salts_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 64
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/salts_update.sv */
`timescale 1ns / 1ps

module salts_update
    import salts_pkg::*;
#(
    parameter int WAYS     = WAYS_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF,
    parameter int WAY_W    = 2,
    parameter int ROW_W    = WAYS * (TAG_BITS + STATE_W + WAY_W)
) (
    input  logic [ROW_W-1:0]    i_row,
    input  t_req_op             i_op,
    input  logic [TAG_BITS-1:0] i_tag,
    input  logic [STATE_W-1:0]  i_new_state,
    output logic [ROW_W-1:0]    o_row,
    output t_result             o_result
);

    localparam int WAY_BITS = TAG_BITS + STATE_W + WAY_W;

    logic [TAG_BITS-1:0] way_tag   [WAYS];
    logic [STATE_W-1:0]  way_state [WAYS];
    logic [WAY_W-1:0]    way_rank  [WAYS];
    logic                hit;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    lru_way;
    logic [WAY_W-1:0]    tgt_way;
    logic [WAY_W-1:0]    tgt_rank;
    logic [STATE_W-1:0]  victim_state;
    logic                do_tag;
    logic                do_state;
    logic                do_mru;

    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        lru_way = '0;
        for (int w = 0; w < WAYS; w++) begin
            way_rank[w]  = i_row[w*WAY_BITS +: WAY_W];
            way_state[w] = i_row[w*WAY_BITS + WAY_W +: STATE_W];
            way_tag[w]   = i_row[w*WAY_BITS + WAY_W + STATE_W +: TAG_BITS];
        end
        // The first matching way wins; the LRU way is the one ranked last.
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (way_tag[w] == i_tag) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            if (way_rank[w] == WAY_W'(WAYS - 1)) begin
                lru_way = WAY_W'(w);
            end
        end
    end

    always_comb begin
        victim_state          = way_state[lru_way];
        o_result.line_state   = hit ? way_state[hit_way] : ST_INVALID;
        o_result.victim_dirty = (victim_state == ST_OWNED) || (victim_state == ST_MODIFIED);

        do_tag   = 1'b0;
        do_state = 1'b0;
        do_mru   = 1'b0;
        tgt_way  = hit_way;
        case (i_op)
            REQ_CHANGE: begin
                do_state = hit;
            end
            REQ_TOUCH: begin
                do_mru = hit;
            end
            REQ_INSERT: begin
                do_state = 1'b1;
                do_mru   = 1'b1;
                do_tag   = !hit;
                tgt_way  = hit ? hit_way : lru_way;
            end
            default: begin
            end
        endcase
        tgt_rank = way_rank[tgt_way];
    end

    always_comb begin
        o_row = i_row;
        for (int w = 0; w < WAYS; w++) begin
            if (do_tag && (tgt_way == WAY_W'(w))) begin
                o_row[w*WAY_BITS + WAY_W + STATE_W +: TAG_BITS] = i_tag;
            end
            if (do_state && (tgt_way == WAY_W'(w))) begin
                o_row[w*WAY_BITS + WAY_W +: STATE_W] = i_new_state;
            end
            if (do_mru) begin
                if (tgt_way == WAY_W'(w)) begin
                    o_row[w*WAY_BITS +: WAY_W] = '0;
                end else if (way_rank[w] < tgt_rank) begin
                    o_row[w*WAY_BITS +: WAY_W] = WAY_W'(way_rank[w] + 1'b1);
                end
            end
        end
    end

endmodule

/* sv/set_assoc_lru_tag_store.sv */
// An accepted request word starts a read-modify-write of the single set
// memory: its set row is read, then the result word is registered and the
// row written back at commit, which waits while an untaken result holds the
// output register; no new word is taken before that commit. After reset the
// block clears the set memory, one set per cycle, and takes no word till done.
`timescale 1ns / 1ps

module set_assoc_lru_tag_store
    import salts_pkg::*;
#(
    parameter int SETS     = SETS_DEF,
    parameter int WAYS     = WAYS_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_req_type,
    input  logic [SET_IDX_W-1:0] i_set_index,
    input  logic [TAG_IN_W-1:0]  i_tag,
    input  logic [STATE_W-1:0]   i_new_state,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [STATE_W-1:0]   o_line_state,
    output logic                 o_victim_dirty
);

    localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAY_BITS = TAG_BITS + STATE_W + WAY_W;
    localparam int ROW_W    = WAYS * WAY_BITS;
    localparam int IDX_CNT  = 2 ** SET_IDX_W;

    // The set index wraps modulo SETS; the wrap is a constant table built
    // at elaboration, indexed by the narrow request field.
    typedef logic [SET_W-1:0] t_set_lut [IDX_CNT];

    function automatic t_set_lut build_set_lut();
        t_set_lut lut;
        for (int i = 0; i < IDX_CNT; i++) begin
            lut[i] = SET_W'(i % SETS);
        end
        return lut;
    endfunction

    localparam t_set_lut SET_LUT = build_set_lut();

    // Contents of every set after reset: way j holds tag j, invalid, and
    // ranked so that way 0 is least recently used.
    function automatic logic [ROW_W-1:0] reset_row();
        logic [ROW_W-1:0] row;
        row = '0;
        for (int w = 0; w < WAYS; w++) begin
            row[w*WAY_BITS +: WAY_W]                      = WAY_W'(WAYS - 1 - w);
            row[w*WAY_BITS + WAY_W +: STATE_W]            = ST_INVALID;
            row[w*WAY_BITS + WAY_W + STATE_W +: TAG_BITS] = TAG_BITS'(w);
        end
        return row;
    endfunction

    localparam logic [ROW_W-1:0] RESET_ROW = reset_row();

    // Sequencer: clear pass after reset, then idle (ready for a word) and
    // lookup (memory data present, result and write-back pending).
    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_LOOK  = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [SET_W-1:0]    r_clr_cnt, n_clr_cnt;
    logic [SET_W-1:0]    r_set;
    t_req_op             r_op;
    logic [TAG_BITS-1:0] r_tag;
    logic [STATE_W-1:0]  r_new_state;
    logic                r_out_valid, n_out_valid;
    t_result             r_result;

    logic                accept;
    logic                commit;
    logic [SET_W-1:0]    rd_set;
    logic [ROW_W-1:0]    rd_row;
    logic [ROW_W-1:0]    upd_row;
    t_result             upd_result;
    logic                wr_en;
    logic [SET_W-1:0]    wr_addr;
    logic [ROW_W-1:0]    wr_data;
    logic [63:0]         tag_wide;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    // The result word may enter the output register once it is empty or
    // being taken in this cycle; the write-back happens in the same cycle.
    assign commit     = (r_state == ST_LOOK) && (!r_out_valid || i_out_ready);
    assign rd_set     = SET_LUT[i_set_index];
    assign tag_wide   = {32'b0, i_tag};

    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        case (r_state)
            ST_CLEAR: begin
                n_clr_cnt = SET_W'(r_clr_cnt + 1'b1);
                if (r_clr_cnt == SET_W'(SETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Request fields held for the lookup cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_set       <= rd_set;
            r_op        <= t_req_op'(i_req_type);
            r_tag       <= tag_wide[TAG_BITS-1:0];
            r_new_state <= i_new_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_result <= upd_result;
        end
    end

    // One write port shared by the clear pass and the write-back.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_set;
        wr_data = upd_row;
        if (r_state == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_cnt;
            wr_data = RESET_ROW;
        end else if (commit) begin
            wr_en = 1'b1;
        end
    end

    salts_mem #(
        .DEPTH  (SETS),
        .ADDR_W (SET_W),
        .DATA_W (ROW_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (rd_set),
        .o_rd_data (rd_row),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // Tag compare across all ways, result sampling and the new set row.
    salts_update #(
        .WAYS     (WAYS),
        .TAG_BITS (TAG_BITS),
        .WAY_W    (WAY_W),
        .ROW_W    (ROW_W)
    ) u_update (
        .i_row       (rd_row),
        .i_op        (r_op),
        .i_tag       (r_tag),
        .i_new_state (r_new_state),
        .o_row       (upd_row),
        .o_result    (upd_result)
    );

    assign o_out_valid    = r_out_valid;
    assign o_line_state   = r_result.line_state;
    assign o_victim_dirty = r_result.victim_dirty;

endmodule

/* sv/salts_checker.sv */
`timescale 1ns / 1ps

module salts_checker
    import salts_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic [1:0]           i_req_type,
    input logic [SET_IDX_W-1:0] i_set_index,
    input logic [TAG_IN_W-1:0]  i_tag,
    input logic [STATE_W-1:0]   i_new_state,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [STATE_W-1:0]   o_line_state,
    input logic                 o_victim_dirty
);

    // The clear pass keeps the request side closed right after reset.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_in_ready && !o_out_valid))
        else $error("request or result side open right after reset");

    // A request word that waits keeps its valid and its fields.
    a_request_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=>
            (i_in_valid && $stable(i_req_type) && $stable(i_set_index) &&
             $stable(i_tag) && $stable(i_new_state)))
        else $error("waiting request word changed or dropped");

    // One word at a time: an accepted word closes the request side.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while another is in flight");

    // Every accepted word is followed by a raised result valid after its lookup.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> ##1 o_out_valid)
        else $error("no result word after an accepted request");

    // A result word that is not taken holds.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_line_state) && $stable(o_victim_dirty)))
        else $error("stalled result word changed or dropped");

endmodule

bind set_assoc_lru_tag_store salts_checker u_salts_checker (.*);
